/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the color correction matrix.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge of clk while arst_n is high.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen at a rising edge of clk while arst_n is high.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

/* hw/rtl/ccm_pkg.sv */
// Types and constants of the color correction matrix.
package ccm_pkg;

	localparam int PIXEL_BITS = 12;
	localparam int COEF_BITS  = 16;
	localparam int COEF_FRAC  = COEF_BITS - 4;

	localparam int NUM_COEFS    = 6;
	localparam int CFG_IDX_BITS = 3;

	localparam int NUM_CHANNELS = 3;
	localparam int DIFF_BITS    = PIXEL_BITS + 1;
	localparam int PROD_BITS    = COEF_BITS + DIFF_BITS;
	localparam int ACC_BITS     = COEF_BITS + PIXEL_BITS + 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RED_FROM_GREEN  = 3'd0,
		CFG_RED_FROM_BLUE   = 3'd1,
		CFG_GREEN_FROM_RED  = 3'd2,
		CFG_GREEN_FROM_BLUE = 3'd3,
		CFG_BLUE_FROM_RED   = 3'd4,
		CFG_BLUE_FROM_GREEN = 3'd5
	} cfg_idx_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	typedef struct packed {
		coef_t red_from_green;
		coef_t red_from_blue;
		coef_t green_from_red;
		coef_t green_from_blue;
		coef_t blue_from_red;
		coef_t blue_from_green;
	} coef_set_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] red_in;
		logic [PIXEL_BITS-1:0] green_in;
		logic [PIXEL_BITS-1:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] red_out;
		logic [PIXEL_BITS-1:0] green_out;
		logic [PIXEL_BITS-1:0] blue_out;
	} pixel_out_t;

endpackage

/* hw/rtl/color_correction_matrix.sv */
// Top level of the 3x3 color correction matrix with its four-stage pipeline.
//
// The pixel channel (pixel_valid, pixel_ready, pixel) takes one RGB word per
// cycle while pixel_ready is high; the result channel (result_valid,
// result_ready, result) gives one corrected RGB word for every pixel word, in
// order. Both use valid/ready. The six off-diagonal coefficients are written
// through cfg_we, cfg_index and cfg_wdata; the user must write them only while
// the pipeline is empty, which the block itself does not enforce. Indexes above
// five are ignored. Each diagonal weight is one minus the other two of its row,
// so the block computes out = own + k_a * (a - own) + k_b * (b - own), which is
// the same sum exactly. The pipeline takes one word per cycle while it is not
// stalled; the stages are the input differences, one 16x13 multiplier per
// term, the row sum with rounding, and saturation into the result register.
// Reset clears all valid bits and sets every coefficient to zero, which gives
// the identity matrix. When the receiver stalls, the result register holds its
// word and the stages behind it keep filling their empty slots; pixel_ready
// falls only once all four stages hold a word.
module color_correction_matrix (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pixel_valid,
	output logic                                 pixel_ready,
	input  ccm_pkg::pixel_in_t                   pixel,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output ccm_pkg::pixel_out_t                  result,
	input  logic                                 cfg_we,
	input  logic [ccm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ccm_pkg::COEF_BITS-1:0]        cfg_wdata
);

`include "assert_macros.svh"

	localparam int NC = ccm_pkg::NUM_CHANNELS;

	// Coefficient registers.
	ccm_pkg::coef_set_t coef_q;

	// Handshake: a stage takes a new word when it is empty or its word moves on.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// Per-channel operands: own pixel and the two other pixels with their weights.
	logic        [ccm_pkg::PIXEL_BITS-1:0] own_px   [NC];
	logic        [ccm_pkg::PIXEL_BITS-1:0] a_px     [NC];
	logic        [ccm_pkg::PIXEL_BITS-1:0] b_px     [NC];
	ccm_pkg::coef_t                        k_a      [NC];
	ccm_pkg::coef_t                        k_b      [NC];

	// Pipeline data.
	logic        [ccm_pkg::PIXEL_BITS-1:0] own_s1   [NC];
	logic signed [ccm_pkg::DIFF_BITS-1:0]  diff_a_s1[NC];
	logic signed [ccm_pkg::DIFF_BITS-1:0]  diff_b_s1[NC];
	logic        [ccm_pkg::PIXEL_BITS-1:0] own_s2   [NC];
	logic signed [ccm_pkg::PROD_BITS-1:0]  prod_a_s2[NC];
	logic signed [ccm_pkg::PROD_BITS-1:0]  prod_b_s2[NC];
	logic signed [ccm_pkg::ACC_BITS-1:0]   acc_s3   [NC];
	logic        [ccm_pkg::PIXEL_BITS-1:0] chan_out [NC];
	ccm_pkg::pixel_out_t                   result_s4;

	// Half of one output step, added before the rounding shift.
	localparam logic signed [ccm_pkg::ACC_BITS-1:0] RoundHalf =
		ccm_pkg::ACC_BITS'(1) <<< (ccm_pkg::COEF_FRAC - 1);

	// Clamp a rounded row sum into the pixel range.
	function automatic logic [ccm_pkg::PIXEL_BITS-1:0] round_sat(
		input logic signed [ccm_pkg::ACC_BITS-1:0] acc
	);
		logic [ccm_pkg::ACC_BITS-ccm_pkg::COEF_FRAC-1:0] whole;
		whole = acc[ccm_pkg::ACC_BITS-1:ccm_pkg::COEF_FRAC];
		if (acc[ccm_pkg::ACC_BITS-1]) begin
			return '0;
		end else if (|whole[ccm_pkg::ACC_BITS-ccm_pkg::COEF_FRAC-1:ccm_pkg::PIXEL_BITS]) begin
			return '1;
		end else begin
			return whole[ccm_pkg::PIXEL_BITS-1:0];
		end
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccm_pkg::CFG_RED_FROM_GREEN:  coef_q.red_from_green  <= cfg_wdata;
				ccm_pkg::CFG_RED_FROM_BLUE:   coef_q.red_from_blue   <= cfg_wdata;
				ccm_pkg::CFG_GREEN_FROM_RED:  coef_q.green_from_red  <= cfg_wdata;
				ccm_pkg::CFG_GREEN_FROM_BLUE: coef_q.green_from_blue <= cfg_wdata;
				ccm_pkg::CFG_BLUE_FROM_RED:   coef_q.blue_from_red   <= cfg_wdata;
				ccm_pkg::CFG_BLUE_FROM_GREEN: coef_q.blue_from_green <= cfg_wdata;
				default: begin
					// Indexes past the last register are dropped.
				end
			endcase
		end
	end

	// Stall chain, from the result register back to the input.
	assign en_s4       = !v_s4 || result_ready;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign pixel_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pixel_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Route each output row to its own pixel, the two other pixels and their weights.
	always_comb begin
		own_px[0] = pixel.red_in;
		a_px[0]   = pixel.green_in;
		b_px[0]   = pixel.blue_in;
		k_a[0]    = coef_q.red_from_green;
		k_b[0]    = coef_q.red_from_blue;

		own_px[1] = pixel.green_in;
		a_px[1]   = pixel.red_in;
		b_px[1]   = pixel.blue_in;
		k_a[1]    = coef_q.green_from_red;
		k_b[1]    = coef_q.green_from_blue;

		own_px[2] = pixel.blue_in;
		a_px[2]   = pixel.red_in;
		b_px[2]   = pixel.green_in;
		k_a[2]    = coef_q.blue_from_red;
		k_b[2]    = coef_q.blue_from_green;
	end

	for (genvar c = 0; c < NC; c++) begin : g_chan
		// Stage 1: differences against the row's own pixel.
		always_ff @(posedge clk) begin
			if (en_s1 && pixel_valid) begin
				own_s1[c]    <= own_px[c];
				diff_a_s1[c] <= $signed({1'b0, a_px[c]}) - $signed({1'b0, own_px[c]});
				diff_b_s1[c] <= $signed({1'b0, b_px[c]}) - $signed({1'b0, own_px[c]});
			end
		end

		// Stage 2: one multiplier per off-diagonal term.
		always_ff @(posedge clk) begin
			if (en_s2 && v_s1) begin
				own_s2[c]    <= own_s1[c];
				prod_a_s2[c] <= k_a[c] * diff_a_s1[c];
				prod_b_s2[c] <= k_b[c] * diff_b_s1[c];
			end
		end

		// Stage 3: row sum with the own pixel at unit weight plus the rounding half.
		always_ff @(posedge clk) begin
			if (en_s3 && v_s2) begin
				acc_s3[c] <=
					$signed({{(ccm_pkg::ACC_BITS - ccm_pkg::PIXEL_BITS - ccm_pkg::COEF_FRAC){1'b0}},
						own_s2[c], {ccm_pkg::COEF_FRAC{1'b0}}})
					+ {{(ccm_pkg::ACC_BITS - ccm_pkg::PROD_BITS){prod_a_s2[c][ccm_pkg::PROD_BITS-1]}},
						prod_a_s2[c]}
					+ {{(ccm_pkg::ACC_BITS - ccm_pkg::PROD_BITS){prod_b_s2[c][ccm_pkg::PROD_BITS-1]}},
						prod_b_s2[c]}
					+ RoundHalf;
			end
		end

		assign chan_out[c] = round_sat(acc_s3[c]);
	end

	// Stage 4: saturation into the result register.
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			result_s4.red_out   <= chan_out[0];
			result_s4.green_out <= chan_out[1];
			result_s4.blue_out  <= chan_out[2];
		end
	end

	assign result_valid = v_s4;
	assign result       = result_s4;

	// An empty stage anywhere must leave the input open.
	`ASSERT_CLK(a_ready_when_room,
		($countones({v_s1, v_s2, v_s3, v_s4}) < 4) |-> pixel_ready,
		"pixel_ready low although a pipeline stage is empty")

	// A word in stage 3 behind a stalled result must not move or change.
	`ASSERT_CLK(a_s3_holds_on_stall,
		(v_s4 && !result_ready && v_s3) |=>
			(v_s3 && $stable(acc_s3[0]) && $stable(acc_s3[1]) && $stable(acc_s3[2])),
		"stage 3 word changed while the result was stalled")

	// A negative red sum must come out as zero.
	`ASSERT_CLK(a_neg_sum_clamps,
		(en_s4 && v_s3 && acc_s3[0][ccm_pkg::ACC_BITS-1]) |=> (result.red_out == '0),
		"negative red sum did not saturate to zero")

	// With all coefficients zero the matrix is the identity, so every product is zero.
	`ASSERT_CLK(a_identity_products,
		(en_s2 && v_s1 && (coef_q == '0)) |=>
			((prod_a_s2[0] == '0) && (prod_b_s2[0] == '0) && (prod_a_s2[1] == '0) &&
			 (prod_b_s2[1] == '0) && (prod_a_s2[2] == '0) && (prod_b_s2[2] == '0)),
		"nonzero product with an all-zero coefficient set")

endmodule
